FILE: design/alps_pkg.sv
`default_nettype none
package alps_pkg;

  // default pool capacity
  localparam int unsigned MAX_ENTRIES = 256;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_HOST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_DEFAULT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_MIN     = 3'd4;

  // message opcodes
  localparam logic [1:0] OP_DISCOVER = 2'd0;
  localparam logic [1:0] OP_REQUEST  = 2'd1;

  // reply kinds
  localparam logic [1:0] KIND_OFFER = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_NAK   = 2'd2;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_PENDING  = 2'd1,
    ST_OCCUPIED = 2'd2,
    ST_EXPIRED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // one lease table entry
  typedef struct packed {
    status_e     status;
    logic [15:0] owner;
    logic [31:0] expiry;
  } entry_t;

  // latched message word
  typedef struct packed {
    logic [31:0] now_time;
    logic [15:0] sender_host;
    logic [15:0] target_host;
    logic        target_broadcast;
    logic [1:0]  opcode;
    logic [15:0] asked_address;
    logic [31:0] asked_expiry;
  } msg_t;

  // lease limits from the register file
  typedef struct packed {
    logic [31:0] lease_default;
    logic [31:0] lease_max;
    logic [31:0] lease_min;
  } lease_cfg_t;

endpackage
`default_nettype wire

FILE: design/address_lease_pool_server_top.sv
`default_nettype none
// Lease-pool server. Pulse start_i while busy_o is low to hand in one message;
// the block then sweeps the lease table once, reading one entry per cycle on
// the memory's read port and writing it back on its write port. With
// n = min(pool_size, MAX_ENTRIES), the sweep covers n entries and is followed
// by the write-back of the last entry, a gap and the finish state, which
// places the chosen entry and registers the reply; the reply strobe shows in
// the same cycle in which busy_o drops.
// A reply, when there is one, shows on the result ports for exactly one cycle
// with result_valid_o high and must be captured then: it cannot be stalled.
// After reset the table is swept clear, which keeps busy_o high until every
// entry is cleared. Write registers through cfg_* only while busy_o is low.
module address_lease_pool_server_top #(
  parameter int unsigned MAX_ENTRIES = alps_pkg::MAX_ENTRIES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [alps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  // message in
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] now_time_i,
  input  wire logic [15:0] sender_host_i,
  input  wire logic [15:0] target_host_i,
  input  wire logic        target_broadcast_i,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [15:0] asked_address_i,
  input  wire logic [31:0] asked_expiry_i,
  // reply out
  output logic             result_valid_o,
  output logic [1:0]       reply_kind_o,
  output logic [15:0]      client_host_o,
  output logic [15:0]      reply_address_o,
  output logic [31:0]      reply_expiry_o
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned NW = (CW > 9) ? CW : 9;

  logic [15:0] server_host_q;
  logic [8:0]  pool_size_q;
  alps_pkg::lease_cfg_t lease_q;
  logic [NW-1:0] live;

  alps_pkg::msg_t   msg_in, msg_cur;
  logic [31:0]      grant;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  alps_pkg::entry_t rd_data, wr_data;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_host_q <= 16'd1;
      pool_size_q   <= 9'd256;
      lease_q       <= '{lease_default: 32'd1, lease_max: 32'd1, lease_min: 32'd1};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        alps_pkg::CFG_SERVER_HOST:   server_host_q         <= cfg_wdata_i[15:0];
        alps_pkg::CFG_POOL_SIZE:     pool_size_q           <= cfg_wdata_i[8:0];
        alps_pkg::CFG_LEASE_DEFAULT: lease_q.lease_default <= cfg_wdata_i;
        alps_pkg::CFG_LEASE_MAX:     lease_q.lease_max     <= cfg_wdata_i;
        alps_pkg::CFG_LEASE_MIN:     lease_q.lease_min     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // entries in use, clamped to capacity
  always_comb begin
    if (NW'(pool_size_q) > NW'(MAX_ENTRIES)) begin
      live = NW'(MAX_ENTRIES);
    end else begin
      live = NW'(pool_size_q);
    end
  end

  assign msg_in = '{now_time: now_time_i, sender_host: sender_host_i,
                    target_host: target_host_i, target_broadcast: target_broadcast_i,
                    opcode: opcode_i, asked_address: asked_address_i,
                    asked_expiry: asked_expiry_i};

  alps_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .AW(AW),
    .CW(CW),
    .NW(NW)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .msg_i          (msg_in),
    .msg_o          (msg_cur),
    .live_i         (live),
    .server_host_i  (server_host_q),
    .grant_i        (grant),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .result_valid_o,
    .reply_kind_o,
    .client_host_o,
    .reply_address_o,
    .reply_expiry_o
  );

  alps_grant u_grant (
    .msg_i   (msg_cur),
    .cfg_i   (lease_q),
    .grant_o (grant)
  );

  alps_mem #(
    .DEPTH(MAX_ENTRIES),
    .AW(AW)
  ) u_mem (
    .clk_i,
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule
`default_nettype wire

FILE: design/alps_mem.sv
`default_nettype none
module alps_mem #(
  parameter int unsigned DEPTH = alps_pkg::MAX_ENTRIES,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output alps_pkg::entry_t     rd_data_o,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  alps_pkg::entry_t     wr_data_i
);

  alps_pkg::entry_t mem_q [DEPTH];
  alps_pkg::entry_t rd_data_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: design/alps_grant.sv
`default_nettype none
module alps_grant (
  input  alps_pkg::msg_t       msg_i,
  input  alps_pkg::lease_cfg_t cfg_i,
  output logic [31:0]          grant_o
);

  logic [32:0]        sum_def;
  logic [32:0]        sum_max;
  logic [32:0]        sum_min;
  logic signed [33:0] diff;
  logic signed [33:0] max_s;
  logic signed [33:0] min_s;

  // saturating sums and the signed distance to the asked time
  always_comb begin
    sum_def = {1'b0, msg_i.now_time} + {1'b0, cfg_i.lease_default};
    sum_max = {1'b0, msg_i.now_time} + {1'b0, cfg_i.lease_max};
    sum_min = {1'b0, msg_i.now_time} + {1'b0, cfg_i.lease_min};
    diff    = $signed({2'b00, msg_i.asked_expiry}) - $signed({2'b00, msg_i.now_time});
    max_s   = $signed({2'b00, cfg_i.lease_max});
    min_s   = $signed({2'b00, cfg_i.lease_min});
    if (msg_i.asked_expiry == 32'd0) begin
      grant_o = sum_def[32] ? 32'hFFFF_FFFF : sum_def[31:0];
    end else if (diff > max_s) begin
      grant_o = sum_max[32] ? 32'hFFFF_FFFF : sum_max[31:0];
    end else if (diff < min_s) begin
      grant_o = sum_min[32] ? 32'hFFFF_FFFF : sum_min[31:0];
    end else begin
      grant_o = msg_i.asked_expiry;
    end
  end

endmodule
`default_nettype wire

FILE: design/alps_ctrl.sv
`default_nettype none
module alps_ctrl #(
  parameter int unsigned MAX_ENTRIES = alps_pkg::MAX_ENTRIES,
  parameter int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int unsigned CW = $clog2(MAX_ENTRIES + 1),
  parameter int unsigned NW = (CW > 9) ? CW : 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  alps_pkg::msg_t     msg_i,
  output alps_pkg::msg_t     msg_o,
  input  wire logic [NW-1:0] live_i,
  input  wire logic [15:0]   server_host_i,
  input  wire logic [31:0]   grant_i,
  // memory side
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  input  alps_pkg::entry_t   rd_data_i,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output alps_pkg::entry_t   wr_data_o,
  // result word
  output logic               result_valid_o,
  output logic [1:0]         reply_kind_o,
  output logic [15:0]        client_host_o,
  output logic [15:0]        reply_address_o,
  output logic [31:0]        reply_expiry_o
);

  alps_pkg::state_e state_q, state_d;
  alps_pkg::msg_t   msg_q;

  logic [AW-1:0] clr_q;
  logic [NW-1:0] rd_q;
  logic          vld_q;
  logic [AW-1:0] idx_q;

  logic          own_hit_q, free_hit_q, exp_hit_q;
  logic [AW-1:0] own_idx_q, free_idx_q, exp_idx_q;
  logic          tgt_hit_q;
  alps_pkg::status_e tgt_st_q;
  logic [15:0]   tgt_own_q;

  logic [31:0]   grant_q;

  logic          res_vld_q;
  logic [1:0]    res_kind_q;
  logic [15:0]   res_host_q, res_addr_q;
  logic [31:0]   res_exp_q;

  logic             issue;
  logic             mode_disc, mode_ack, mode_rel;
  alps_pkg::entry_t post;
  logic             owned;
  logic             is_tgt;
  logic             pick_hit;
  logic [AW-1:0]    pick_idx;
  logic             ack_ok;
  logic [16:0]      idx_plus;
  logic [16:0]      pick_plus;
  logic [16:0]      addr_m1;

  // message classes
  always_comb begin
    mode_disc = msg_q.target_broadcast && (msg_q.opcode == alps_pkg::OP_DISCOVER);
    mode_ack  = !msg_q.target_broadcast && (msg_q.opcode == alps_pkg::OP_REQUEST) &&
                (msg_q.target_host == server_host_i);
    mode_rel  = !msg_q.target_broadcast && (msg_q.opcode == alps_pkg::OP_REQUEST) &&
                (msg_q.target_host != server_host_i);
  end

  // expiry and release applied to the entry just read
  always_comb begin
    post = rd_data_i;
    if (rd_data_i.expiry <= msg_q.now_time) begin
      if (rd_data_i.status == alps_pkg::ST_PENDING) begin
        post = '{status: alps_pkg::ST_FREE, owner: 16'd0, expiry: 32'd0};
      end else if (rd_data_i.status == alps_pkg::ST_OCCUPIED) begin
        post.status = alps_pkg::ST_EXPIRED;
        post.expiry = 32'd0;
      end
    end
    owned    = (post.status != alps_pkg::ST_FREE) && (post.owner == msg_q.sender_host);
    idx_plus = 17'(idx_q) + 17'd1;
    is_tgt   = (idx_plus == {1'b0, msg_q.asked_address});
    if (mode_rel && owned && (post.status == alps_pkg::ST_PENDING)) begin
      post = '{status: alps_pkg::ST_FREE, owner: 16'd0, expiry: 32'd0};
    end
  end

  // discover choice: owned, then free, then expired
  always_comb begin
    pick_hit = own_hit_q || free_hit_q || exp_hit_q;
    if (own_hit_q) begin
      pick_idx = own_idx_q;
    end else if (free_hit_q) begin
      pick_idx = free_idx_q;
    end else begin
      pick_idx = exp_idx_q;
    end
    pick_plus = 17'(pick_idx) + 17'd1;
    addr_m1   = {1'b0, msg_q.asked_address} - 17'd1;
    ack_ok    = tgt_hit_q && (tgt_st_q != alps_pkg::ST_FREE) &&
                (tgt_own_q == msg_q.sender_host);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      alps_pkg::S_CLEAR: begin
        if (clr_q == AW'(MAX_ENTRIES - 1)) begin
          state_d = alps_pkg::S_IDLE;
        end
      end
      alps_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = alps_pkg::S_SCAN;
        end
      end
      alps_pkg::S_SCAN: begin
        if ((rd_q >= live_i) && !vld_q) begin
          state_d = alps_pkg::S_FINISH;
        end
      end
      alps_pkg::S_FINISH: begin
        state_d = alps_pkg::S_IDLE;
      end
      default: begin
        state_d = alps_pkg::S_IDLE;
      end
    endcase
  end

  // memory control
  always_comb begin
    busy_o    = (state_q != alps_pkg::S_IDLE);
    issue     = (state_q == alps_pkg::S_SCAN) && (rd_q < live_i);
    rd_en_o   = issue;
    rd_addr_o = rd_q[AW-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q;
    wr_data_o = post;
    case (state_q)
      alps_pkg::S_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        wr_data_o = '{status: alps_pkg::ST_FREE, owner: 16'd0, expiry: 32'd0};
      end
      alps_pkg::S_SCAN: begin
        wr_en_o = vld_q;
      end
      alps_pkg::S_FINISH: begin
        if (mode_disc) begin
          wr_en_o   = pick_hit;
          wr_addr_o = pick_idx;
          wr_data_o = '{status: alps_pkg::ST_PENDING, owner: msg_q.sender_host,
                        expiry: grant_q};
        end else begin
          wr_en_o   = mode_ack && ack_ok;
          wr_addr_o = addr_m1[AW-1:0];
          wr_data_o = '{status: alps_pkg::ST_OCCUPIED, owner: msg_q.sender_host,
                        expiry: grant_q};
        end
      end
      default: begin
        wr_en_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= alps_pkg::S_CLEAR;
      clr_q     <= '0;
      rd_q      <= '0;
      vld_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= 1'b0;
      if (state_q == alps_pkg::S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      vld_q <= issue;
      if (state_q == alps_pkg::S_IDLE) begin
        rd_q <= '0;
      end else if (issue) begin
        rd_q <= rd_q + NW'(1);
      end
      if (state_q == alps_pkg::S_FINISH) begin
        res_vld_q <= (mode_disc && pick_hit) || mode_ack;
      end
    end
  end

  // message, search and result payload
  always_ff @(posedge clk_i) begin
    idx_q   <= rd_q[AW-1:0];
    grant_q <= grant_i;
    if ((state_q == alps_pkg::S_IDLE) && start_i) begin
      msg_q      <= msg_i;
      own_hit_q  <= 1'b0;
      free_hit_q <= 1'b0;
      exp_hit_q  <= 1'b0;
      tgt_hit_q  <= 1'b0;
    end
    if ((state_q == alps_pkg::S_SCAN) && vld_q) begin
      if (owned && !own_hit_q) begin
        own_hit_q <= 1'b1;
        own_idx_q <= idx_q;
      end
      if ((post.status == alps_pkg::ST_FREE) && !free_hit_q) begin
        free_hit_q <= 1'b1;
        free_idx_q <= idx_q;
      end
      if ((post.status == alps_pkg::ST_EXPIRED) && !exp_hit_q) begin
        exp_hit_q <= 1'b1;
        exp_idx_q <= idx_q;
      end
      if (is_tgt) begin
        tgt_hit_q <= 1'b1;
        tgt_st_q  <= post.status;
        tgt_own_q <= post.owner;
      end
    end
    if (state_q == alps_pkg::S_FINISH) begin
      res_host_q <= msg_q.sender_host;
      if (mode_disc) begin
        res_kind_q <= alps_pkg::KIND_OFFER;
        res_addr_q <= pick_plus[15:0];
        res_exp_q  <= grant_q;
      end else if (ack_ok) begin
        res_kind_q <= alps_pkg::KIND_ACK;
        res_addr_q <= msg_q.asked_address;
        res_exp_q  <= grant_q;
      end else begin
        res_kind_q <= alps_pkg::KIND_NAK;
        res_addr_q <= msg_q.asked_address;
        res_exp_q  <= 32'd0;
      end
    end
  end

  assign msg_o           = msg_q;
  assign result_valid_o  = res_vld_q;
  assign reply_kind_o    = res_kind_q;
  assign client_host_o   = res_host_q;
  assign reply_address_o = res_addr_q;
  assign reply_expiry_o  = res_exp_q;

endmodule
`default_nettype wire

FILE: design/alps_checker.sv
`default_nettype none
module alps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        result_valid_o,
  input wire logic [1:0]  reply_kind_o,
  input wire logic [31:0] reply_expiry_o
);

  // an accepted message keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted message did not raise busy");

  // replies are single-cycle strobes
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("reply strobe held for two cycles");

  // a reply marks the end of the message
  a_reply_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("reply while still busy");

  // refusals carry no lease
  a_nak_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (reply_kind_o == alps_pkg::KIND_NAK)) |-> (reply_expiry_o == 32'd0))
    else $error("negative reply with nonzero expiry");

  // only defined reply kinds
  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (reply_kind_o == alps_pkg::KIND_OFFER ||
                        reply_kind_o == alps_pkg::KIND_ACK ||
                        reply_kind_o == alps_pkg::KIND_NAK))
    else $error("undefined reply kind");

endmodule

bind address_lease_pool_server_top alps_checker u_alps_checker (
  .clk_i,
  .rst_ni,
  .start_i,
  .busy_o,
  .result_valid_o,
  .reply_kind_o,
  .reply_expiry_o
);
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

// reply scoreboard: holds predicted replies in order
class reply_board;
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] client;
    logic [15:0] addr;
    logic [31:0] expiry;
  } reply_t;

  reply_t pending_q[$];
  int     errors;

  function new();
    errors = 0;
  endfunction

  function void note(reply_t r);
    pending_q = {pending_q, r};
  endfunction

  function void check(reply_t got);
    reply_t want;
    if (pending_q.size() == 0) begin
      $error("unexpected reply kind=%0d addr=%0d", got.kind, got.addr);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (want.kind !== got.kind) begin
      $error("reply_kind expected %0d actual %0d", want.kind, got.kind);
      errors++;
    end
    if (want.client !== got.client) begin
      $error("client_host expected %0d actual %0d", want.client, got.client);
      errors++;
    end
    if (want.addr !== got.addr) begin
      $error("reply_address expected %0d actual %0d", want.addr, got.addr);
      errors++;
    end
    if (want.expiry !== got.expiry) begin
      $error("reply_expiry expected %0h actual %0h", want.expiry, got.expiry);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int N = alps_pkg::MAX_ENTRIES;
  localparam int WATCHDOG = 20000;
  // register index past the defined list
  localparam logic [alps_pkg::CFG_IDX_W-1:0] CFG_NO_REG = '1;
  // message kinds outside discover and request
  localparam logic [1:0] OP_OTHER = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [alps_pkg::CFG_IDX_W-1:0] cfg_idx_i = alps_pkg::CFG_SERVER_HOST;
  logic [31:0] cfg_wdata_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] now_time_i = '0;
  logic [15:0] sender_host_i = '0;
  logic [15:0] target_host_i = '0;
  logic        target_broadcast_i = 1'b0;
  logic [1:0]  opcode_i = '0;
  logic [15:0] asked_address_i = '0;
  logic [31:0] asked_expiry_i = '0;
  logic        result_valid_o;
  logic [1:0]  reply_kind_o;
  logic [15:0] client_host_o;
  logic [15:0] reply_address_o;
  logic [31:0] reply_expiry_o;

  address_lease_pool_server_top DUT (.*);

  always #1 clk_i = ~clk_i;

  reply_board board = new();

  // predictor copy of registers and lease table
  logic [15:0] m_server;
  logic [8:0]  m_pool;
  logic [31:0] m_def, m_max, m_min;
  alps_pkg::status_e m_status[N];
  logic [15:0] m_owner[N];
  logic [31:0] m_expiry[N];
  logic [31:0] clock_now;
  int          idle_cycles;

  // result capture and watchdog
  always @(posedge clk_i) begin
    if (result_valid_o)
      board.check({reply_kind_o, client_host_o, reply_address_o, reply_expiry_o});
    if (result_valid_o || (start_i && !busy_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] lease_grant(logic [31:0] now, logic [31:0] asked);
    longint diff;
    if (asked == 0) return sat_sum(now, m_def);
    diff = longint'({32'd0, asked}) - longint'({32'd0, now});
    if (diff > longint'({32'd0, m_max})) return sat_sum(now, m_max);
    if (diff < longint'({32'd0, m_min})) return sat_sum(now, m_min);
    return asked;
  endfunction

  // predict the reply of one accepted message
  task automatic predict_message(logic [31:0] now, logic [15:0] snd, logic [15:0] tgt,
                                 logic bc, logic [1:0] op, logic [15:0] addr,
                                 logic [31:0] asked);
    int n;
    int pick;
    logic [31:0] ex;
    n = (m_pool > N) ? N : m_pool;
    pick = 0;
    for (int i = 0; i < n; i++)
      if (m_expiry[i] <= now) begin
        if (m_status[i] == alps_pkg::ST_PENDING) begin
          m_status[i] = alps_pkg::ST_FREE; m_owner[i] = '0; m_expiry[i] = '0;
        end else if (m_status[i] == alps_pkg::ST_OCCUPIED) begin
          m_status[i] = alps_pkg::ST_EXPIRED; m_expiry[i] = '0;
        end
      end
    if (bc) begin
      if (op != alps_pkg::OP_DISCOVER) return;
      for (int i = 0; i < n && pick == 0; i++)
        if (m_status[i] != alps_pkg::ST_FREE && m_owner[i] == snd) pick = i + 1;
      for (int i = 0; i < n && pick == 0; i++)
        if (m_status[i] == alps_pkg::ST_FREE) pick = i + 1;
      for (int i = 0; i < n && pick == 0; i++)
        if (m_status[i] == alps_pkg::ST_EXPIRED) pick = i + 1;
      if (pick == 0) return;
      ex = lease_grant(now, asked);
      m_status[pick-1] = alps_pkg::ST_PENDING; m_owner[pick-1] = snd; m_expiry[pick-1] = ex;
      board.note({alps_pkg::KIND_OFFER, snd, 16'(pick), ex});
      return;
    end
    if (op != alps_pkg::OP_REQUEST) return;
    if (tgt != m_server) begin
      for (int i = 0; i < n; i++)
        if (m_status[i] == alps_pkg::ST_PENDING && m_owner[i] == snd) begin
          m_status[i] = alps_pkg::ST_FREE; m_owner[i] = '0; m_expiry[i] = '0;
        end
      return;
    end
    if (addr >= 1 && addr <= n && m_status[addr-1] != alps_pkg::ST_FREE &&
        m_owner[addr-1] == snd) begin
      ex = lease_grant(now, asked);
      m_status[addr-1] = alps_pkg::ST_OCCUPIED; m_expiry[addr-1] = ex;
      board.note({alps_pkg::KIND_ACK, snd, addr, ex});
    end else
      board.note({alps_pkg::KIND_NAK, snd, addr, 32'd0});
  endtask

  // register write, only while idle
  task automatic write_reg(logic [alps_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      alps_pkg::CFG_SERVER_HOST:   m_server = val[15:0];
      alps_pkg::CFG_POOL_SIZE:     m_pool = val[8:0];
      alps_pkg::CFG_LEASE_DEFAULT: m_def = val;
      alps_pkg::CFG_LEASE_MAX:     m_max = val;
      alps_pkg::CFG_LEASE_MIN:     m_min = val;
      default: ;
    endcase
  endtask

  // hand in one message word
  task automatic send_message(logic [31:0] now, logic [15:0] snd, logic [15:0] tgt,
                              logic bc, logic [1:0] op, logic [15:0] addr,
                              logic [31:0] asked);
    repeat ($urandom_range(0, 8)) @(posedge clk_i);
    @(posedge clk_i);
    start_i <= 1'b1;
    now_time_i <= now; sender_host_i <= snd; target_host_i <= tgt;
    target_broadcast_i <= bc; opcode_i <= op; asked_address_i <= addr;
    asked_expiry_i <= asked;
    do @(posedge clk_i); while (busy_o);
    start_i <= 1'b0;
    predict_message(now, snd, tgt, bc, op, addr, asked);
  endtask

  // wait for outstanding replies plus one full sweep
  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending_q.size() != 0 && guard < WATCHDOG) begin
      @(posedge clk_i); guard++;
    end
    repeat (N + 20) @(posedge clk_i);
  endtask

  // random message, mostly well-formed for a small host population
  task automatic random_message();
    logic [15:0] snd, addr, tgt;
    logic [31:0] asked;
    logic bc;
    logic [1:0] op;
    int pick;
    clock_now = sat_sum(clock_now, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 0);
    if ($urandom_range(0, 50) == 0) clock_now = sat_sum(clock_now, $urandom);
    snd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    addr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, m_pool + 1));
    case ($urandom_range(0, 3))
      0: asked = 0;
      1: asked = $urandom;
      default: asked = clock_now + $urandom_range(0, 60);
    endcase
    pick = $urandom_range(0, 9);
    bc = 1'b0; op = alps_pkg::OP_REQUEST; tgt = m_server;
    if (pick < 4) begin bc = 1'b1; op = alps_pkg::OP_DISCOVER; end
    else if (pick < 7) ;
    else if (pick == 7) tgt = 16'($urandom);
    else begin
      bc = 1'($urandom); op = 2'($urandom); tgt = ($urandom_range(0, 1)) ? m_server : 16'($urandom);
    end
    send_message(clock_now, snd, tgt, bc, op, addr, asked);
  endtask

  initial begin
    for (int i = 0; i < N; i++) begin
      m_status[i] = alps_pkg::ST_FREE; m_owner[i] = '0; m_expiry[i] = '0;
    end
    m_server = 16'd1; m_pool = 9'd256; m_def = 1; m_max = 1; m_min = 1;
    clock_now = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset setup, discovers, requests, filters, saturation
    send_message(0, 16'd7, 16'd0, 1'b1, alps_pkg::OP_DISCOVER, 16'd0, 32'd0);
    send_message(0, 16'd7, 16'd1, 1'b0, alps_pkg::OP_REQUEST, 16'd1, 32'd0);
    send_message(0, 16'd7, 16'd1, 1'b0, alps_pkg::OP_REQUEST, 16'd0, 32'd5);
    send_message(0, 16'd7, 16'd1, 1'b0, alps_pkg::OP_REQUEST, 16'hFFFF, 32'd5);
    send_message(0, 16'd8, 16'd1, 1'b0, alps_pkg::OP_REQUEST, 16'd1, 32'd5);
    send_message(0, 16'd7, 16'd0, 1'b1, alps_pkg::OP_REQUEST, 16'd1, 32'd5);
    send_message(0, 16'd7, 16'd1, 1'b0, OP_OTHER, 16'd1, 32'd5);
    send_message(0, 16'd7, 16'd1, 1'b0, OP_SPARE, 16'd1, 32'd5);
    send_message(0, 16'd9, 16'd0, 1'b1, alps_pkg::OP_DISCOVER, 16'd0, 32'hFFFF_FFFF);
    send_message(0, 16'd9, 16'd5, 1'b0, alps_pkg::OP_REQUEST, 16'd0, 32'd0);
    drain();
    write_reg(alps_pkg::CFG_SERVER_HOST, 32'hFFFF);
    write_reg(alps_pkg::CFG_POOL_SIZE, 32'd2);
    write_reg(alps_pkg::CFG_LEASE_DEFAULT, 32'hFFFF_FFFF);
    write_reg(alps_pkg::CFG_LEASE_MAX, 32'd100);
    write_reg(alps_pkg::CFG_LEASE_MIN, 32'd200);
    send_message(32'hFFFF_FFF0, 16'hFFFF, 16'd0, 1'b1, alps_pkg::OP_DISCOVER, 16'd0, 32'd0);
    send_message(32'hFFFF_FFF0, 16'd1, 16'd0, 1'b1, alps_pkg::OP_DISCOVER, 16'd0, 32'd1);
    send_message(32'hFFFF_FFF0, 16'd2, 16'd0, 1'b1, alps_pkg::OP_DISCOVER, 16'd0, 32'd3);
    send_message(32'hFFFF_FFF0, 16'd1, 16'hFFFF, 1'b0, alps_pkg::OP_REQUEST, 16'd2,
                 32'hFFFF_FFF8);
    send_message(32'hFFFF_FFFF, 16'd3, 16'd0, 1'b1, alps_pkg::OP_DISCOVER, 16'd0, 32'd0);
    drain();
    write_reg(alps_pkg::CFG_POOL_SIZE, 32'd0);
    send_message(32'hFFFF_FFFF, 16'd3, 16'd0, 1'b1, alps_pkg::OP_DISCOVER, 16'd0, 32'd0);
    send_message(32'hFFFF_FFFF, 16'd3, 16'hFFFF, 1'b0, alps_pkg::OP_REQUEST, 16'd1, 32'd0);
    drain();
    write_reg(alps_pkg::CFG_POOL_SIZE, 32'h1FF);
    write_reg(CFG_NO_REG, 32'h1234);
    send_message(32'hFFFF_FFFF, 16'd3, 16'd0, 1'b1, alps_pkg::OP_DISCOVER, 16'd0, 32'd0);
    drain();

    // random phases with varied registers; the time base is not reset between
    // phases, so time keeps climbing from one phase into the next
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(alps_pkg::CFG_SERVER_HOST, (ph % 2) ? $urandom : 32'($urandom_range(0, 3)));
      write_reg(alps_pkg::CFG_POOL_SIZE, (ph == 7) ? 32'h1FF : 32'($urandom_range(1, 12)));
      write_reg(alps_pkg::CFG_LEASE_DEFAULT,
                (ph == 3) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 80)));
      write_reg(alps_pkg::CFG_LEASE_MAX,
                (ph == 4) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 60)));
      write_reg(alps_pkg::CFG_LEASE_MIN,
                (ph == 5) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 30)));
      // time must not go backwards
      for (int k = 0; k < ((ph == 7) ? 60 : 260); k++) random_message();
      drain();
    end

    if (board.pending_q.size() == 0 && board.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
